[src/assert_macros.svh]
// Assertion macros for the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ppm_pkg.sv]
// Package: widths, character codes, phase type and item structs of the P3 parser.
package ppm_pkg;

  localparam int DIM_BITS = 16;
  localparam int CNT_W    = 32;
  localparam int PROD_W   = (2 * DIM_BITS > CNT_W) ? 2 * DIM_BITS : CNT_W;

  localparam logic [7:0] CH_0  = 8'd48;
  localparam logic [7:0] CH_9  = 8'd57;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_SP = 8'd32;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef enum logic [3:0] {
    PH_SIG0 = 4'd0,
    PH_SIG1 = 4'd1,
    PH_WID  = 4'd2,
    PH_HGT  = 4'd3,
    PH_MAX  = 4'd4,
    PH_RED  = 4'd5,
    PH_GRN  = 4'd6,
    PH_BLU  = 4'd7,
    PH_DONE = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [DIM_BITS-1:0] max_level;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [CNT_W-1:0]    pixel_index;
    logic                last;
    logic                truncated;
  } res_t;

endpackage

[src/ppm_in_if.sv]
// Interface: byte input channel of the P3 parser.
interface ppm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

[src/ppm_out_if.sv]
// Interface: result channel of the P3 parser (header and pixel items).
interface ppm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ppm_pkg::DIM_BITS-1:0] width;
  logic [ppm_pkg::DIM_BITS-1:0] height;
  logic [ppm_pkg::DIM_BITS-1:0] max_level;
  logic [7:0]                   red;
  logic [7:0]                   green;
  logic [7:0]                   blue;
  logic [ppm_pkg::CNT_W-1:0]    pixel_index;
  logic                         last;
  logic                         truncated;

  modport source (output valid, output kind, output width, output height, output max_level,
                  output red, output green, output blue, output pixel_index, output last,
                  output truncated, input ready);
  modport sink   (input valid, input kind, input width, input height, input max_level,
                  input red, input green, input blue, input pixel_index, input last,
                  input truncated, output ready);
endinterface

[src/ppm_parse_core.sv]
// Parser core: phase machine, decimal accumulators, pixel counter and result build.
module ppm_parse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  ppm_pkg::in_item_t item,
  output logic              res_valid,
  output ppm_pkg::res_t     res
);

  localparam int DB = ppm_pkg::DIM_BITS;
  localparam int CW = ppm_pkg::CNT_W;
  localparam int PW = ppm_pkg::PROD_W;

  ppm_pkg::phase_t phase_r, phase_nxt;
  logic [DB-1:0]   width_r, width_nxt;
  logic [DB-1:0]   height_r, height_nxt;
  logic [DB-1:0]   maxval_r, maxval_nxt;
  logic [7:0]      red_r, red_nxt;
  logic [7:0]      green_r, green_nxt;
  logic [7:0]      blue_r, blue_nxt;
  logic            digit_seen_r, digit_seen_nxt;
  logic [CW-1:0]   pixel_count_r, pixel_count_nxt;
  logic [CW-1:0]   last_idx_r, last_idx_nxt;
  logic [CW-1:0]   prod_r, prod_nxt;

  logic          is_digit;
  logic          is_term;
  logic [3:0]    dval;
  logic [DB-1:0] hdr_acc;
  logic [DB+3:0] hdr_wide;
  logic [DB-1:0] hdr_sat;
  logic          hdr_end;
  logic [7:0]    ch_acc;
  logic [7:0]    ch_new;
  logic          ch_end;
  logic          is_last;
  logic [PW-1:0] prod_full;
  ppm_pkg::res_t pix_res;

  assign is_digit = (item.data_byte >= ppm_pkg::CH_0) && (item.data_byte <= ppm_pkg::CH_9);
  assign is_term  = (item.data_byte == ppm_pkg::CH_LF) || (item.data_byte == ppm_pkg::CH_CR) ||
                    (item.data_byte == ppm_pkg::CH_SP);
  assign dval     = 4'(item.data_byte - ppm_pkg::CH_0);

  always_comb begin
    unique case (phase_r)
      ppm_pkg::PH_WID: hdr_acc = width_r;
      ppm_pkg::PH_HGT: hdr_acc = height_r;
      default:         hdr_acc = maxval_r;
    endcase
  end

  assign hdr_wide = ({4'b0, hdr_acc} << 3) + ({4'b0, hdr_acc} << 1) + (DB + 4)'(dval);
  assign hdr_sat  = (|hdr_wide[DB+3:DB]) ? {DB{1'b1}} : hdr_wide[DB-1:0];
  assign hdr_end  = is_term && (hdr_acc != '0);

  always_comb begin
    unique case (phase_r)
      ppm_pkg::PH_RED: ch_acc = red_r;
      ppm_pkg::PH_GRN: ch_acc = green_r;
      default:         ch_acc = blue_r;
    endcase
  end

  assign ch_new  = (ch_acc << 3) + (ch_acc << 1) + {4'b0, dval};
  assign ch_end  = !is_digit && digit_seen_r;
  assign is_last = (pixel_count_r == last_idx_r);

  // pixel total, saturated to the counter width and registered; width and height
  // are already stable before the header ends
  assign prod_full = PW'(width_r) * PW'(height_r);
  assign prod_nxt  = (|(prod_full >> CW)) ? {CW{1'b1}} : prod_full[CW-1:0];

  always_comb begin
    pix_res             = '0;
    pix_res.kind        = ppm_pkg::KIND_PIXEL;
    pix_res.red         = red_r;
    pix_res.green       = green_r;
    pix_res.blue        = blue_r;
    pix_res.pixel_index = pixel_count_r;
    pix_res.last        = is_last;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        ppm_pkg::PH_SIG0: phase_nxt = item.end_of_stream ? ppm_pkg::PH_DONE : ppm_pkg::PH_SIG1;
        ppm_pkg::PH_SIG1: phase_nxt = item.end_of_stream ? ppm_pkg::PH_DONE : ppm_pkg::PH_WID;
        ppm_pkg::PH_WID: begin
          priority if (item.end_of_stream) phase_nxt = ppm_pkg::PH_DONE;
          else if (hdr_end)                phase_nxt = ppm_pkg::PH_HGT;
        end
        ppm_pkg::PH_HGT: begin
          priority if (item.end_of_stream) phase_nxt = ppm_pkg::PH_DONE;
          else if (hdr_end)                phase_nxt = ppm_pkg::PH_MAX;
        end
        ppm_pkg::PH_MAX: begin
          priority if (item.end_of_stream) phase_nxt = ppm_pkg::PH_DONE;
          else if (hdr_end)
            phase_nxt = (prod_r == '0) ? ppm_pkg::PH_DONE : ppm_pkg::PH_RED;
        end
        ppm_pkg::PH_RED: begin
          priority if (item.end_of_stream) phase_nxt = ppm_pkg::PH_DONE;
          else if (ch_end)                 phase_nxt = ppm_pkg::PH_GRN;
        end
        ppm_pkg::PH_GRN: begin
          priority if (item.end_of_stream) phase_nxt = ppm_pkg::PH_DONE;
          else if (ch_end)                 phase_nxt = ppm_pkg::PH_BLU;
        end
        ppm_pkg::PH_BLU: begin
          priority if (item.end_of_stream) phase_nxt = ppm_pkg::PH_DONE;
          else if (ch_end) phase_nxt = is_last ? ppm_pkg::PH_DONE : ppm_pkg::PH_RED;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    width_nxt       = width_r;
    height_nxt      = height_r;
    maxval_nxt      = maxval_r;
    red_nxt         = red_r;
    green_nxt       = green_r;
    blue_nxt        = blue_r;
    digit_seen_nxt  = digit_seen_r;
    pixel_count_nxt = pixel_count_r;
    last_idx_nxt    = last_idx_r;
    res_valid       = 1'b0;
    res             = '0;
    if (fire && !item.end_of_stream) begin
      unique case (phase_r)
        ppm_pkg::PH_WID: begin
          if (!hdr_end && is_digit) width_nxt = hdr_sat;
        end
        ppm_pkg::PH_HGT: begin
          if (!hdr_end && is_digit) height_nxt = hdr_sat;
        end
        ppm_pkg::PH_MAX: begin
          priority if (hdr_end) begin
            res_valid      = 1'b1;
            res.kind       = ppm_pkg::KIND_HEADER;
            res.width      = width_r;
            res.height     = height_r;
            res.max_level  = maxval_r;
            last_idx_nxt   = prod_r - CW'(1);
            red_nxt        = '0;
            green_nxt      = '0;
            blue_nxt       = '0;
            digit_seen_nxt = 1'b0;
          end else if (is_digit) begin
            maxval_nxt = hdr_sat;
          end
        end
        ppm_pkg::PH_RED, ppm_pkg::PH_GRN, ppm_pkg::PH_BLU: begin
          priority if (is_digit) begin
            digit_seen_nxt = 1'b1;
            unique case (phase_r)
              ppm_pkg::PH_RED: red_nxt   = ch_new;
              ppm_pkg::PH_GRN: green_nxt = ch_new;
              default:         blue_nxt  = ch_new;
            endcase
          end else if (digit_seen_r) begin
            digit_seen_nxt = 1'b0;
            if (phase_r == ppm_pkg::PH_BLU) begin
              res_valid = 1'b1;
              res       = pix_res;
              red_nxt   = '0;
              green_nxt = '0;
              blue_nxt  = '0;
              if (!is_last) pixel_count_nxt = pixel_count_r + CW'(1);
            end
          end
        end
        default: res_valid = 1'b0;
      endcase
    end else if (fire) begin
      // end of stream: flush a partial pixel that has at least one digit
      if ((phase_r == ppm_pkg::PH_RED && digit_seen_r) || phase_r == ppm_pkg::PH_GRN ||
          phase_r == ppm_pkg::PH_BLU) begin
        res_valid     = 1'b1;
        res           = pix_res;
        res.truncated = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= ppm_pkg::PH_SIG0;
      width_r       <= '0;
      height_r      <= '0;
      maxval_r      <= '0;
      red_r         <= '0;
      green_r       <= '0;
      blue_r        <= '0;
      digit_seen_r  <= 1'b0;
      pixel_count_r <= '0;
      last_idx_r    <= '0;
    end else begin
      phase_r       <= phase_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      maxval_r      <= maxval_nxt;
      red_r         <= red_nxt;
      green_r       <= green_nxt;
      blue_r        <= blue_nxt;
      digit_seen_r  <= digit_seen_nxt;
      pixel_count_r <= pixel_count_nxt;
      last_idx_r    <= last_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

[src/ppm_out_buf.sv]
// Result buffer: output register plus one skid entry.
module ppm_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ppm_pkg::res_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output ppm_pkg::res_t out_data
);

  logic          out_v_r, out_v_nxt;
  logic          skid_v_r, skid_v_nxt;
  ppm_pkg::res_t out_d_r, out_d_nxt;
  ppm_pkg::res_t skid_d_r, skid_d_nxt;
  logic          drain;

  assign drain     = !out_v_r || out_ready;
  assign space     = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    priority if (drain && skid_v_r) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = push;
      skid_d_nxt = push_data;
    end else if (drain) begin
      out_v_nxt = push;
      out_d_nxt = push_data;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

[src/ascii_ppm_stream_parser.sv]
// Top level: ASCII P3 image parser with input register, core and result buffer.
//
//   channel   dir  payload                                          role
//   in_ch     in   data_byte, end_of_stream                         file bytes
//   out_ch    out  kind, width, height, max_level, red, green,      header / pixels
//                  blue, pixel_index, last, truncated
//
// One byte per cycle while the skid entry is empty; each byte waits in the input
// register until the core takes it, and its result is registered in the output
// register, or in the skid entry when the output is stalled.
// Reset clears the phase, accumulators, counters and all valid flags.
// A stalled output fills the skid entry; input then stalls until it drains.
`include "assert_macros.svh"

module ascii_ppm_stream_parser (
  input logic    clk,
  input logic    rst_n,
  ppm_in_if.sink    in_ch,
  ppm_out_if.source out_ch
);

  logic              hold_v_r, hold_v_nxt;
  ppm_pkg::in_item_t hold_item_r;
  logic              fire;
  logic              buf_space;
  logic              in_acc;
  logic              res_valid;
  ppm_pkg::res_t     res;
  ppm_pkg::res_t     out_data;

  assign fire         = hold_v_r && buf_space;
  assign in_ch.ready  = !hold_v_r || fire;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    hold_v_nxt = hold_v_r;
    priority if (in_acc) hold_v_nxt = 1'b1;
    else if (fire)       hold_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_item_r.data_byte     <= in_ch.data_byte;
      hold_item_r.end_of_stream <= in_ch.end_of_stream;
    end
  end

  ppm_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (hold_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  ppm_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (buf_space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.kind        = out_data.kind;
  assign out_ch.width       = out_data.width;
  assign out_ch.height      = out_data.height;
  assign out_ch.max_level   = out_data.max_level;
  assign out_ch.red         = out_data.red;
  assign out_ch.green       = out_data.green;
  assign out_ch.blue        = out_data.blue;
  assign out_ch.pixel_index = out_data.pixel_index;
  assign out_ch.last        = out_data.last;
  assign out_ch.truncated   = out_data.truncated;

  `ASSERT_IMPLY(a_res_needs_fire, res_valid, fire, "result without a processed item")
  `ASSERT_IMPLY(a_skid_needs_out, !buf_space, out_ch.valid, "skid entry full with output empty")
  `ASSERT_NEXT(a_nothing_after_last, res_valid && res.kind == ppm_pkg::KIND_PIXEL && res.last,
               !res_valid, "result after the final pixel")

endmodule
